// ===== hw/rtl/slb_pkg.sv =====
// ----------------------------------------------------------------------------
// slb_pkg
// Shared types, codes and colour constants for the status LED beacon.
// ----------------------------------------------------------------------------
package slb_pkg;

    localparam int SLB_TIME_BITS = 32;
    localparam int NOW_W         = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int LEVEL_W       = 8;

    typedef enum logic [1:0] {
        ACT_SET      = 2'd0,
        ACT_ACTIVITY = 2'd1,
        ACT_TICK     = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        MODE_BOOT     = 3'd0,
        MODE_READY    = 3'd1,
        MODE_LOST     = 3'd2,
        MODE_BROWNOUT = 3'd3,
        MODE_OFF      = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVITY_GAP  = 2'd0,
        CFG_PULSE_LENGTH  = 2'd1,
        CFG_LOST_HALF     = 2'd2,
        CFG_BROWNOUT_HALF = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] activity_gap_ms;
        logic [CFG_W-1:0] pulse_length_ms;
        logic [CFG_W-1:0] lost_half_period_ms;
        logic [CFG_W-1:0] brownout_half_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_t;

    localparam logic [CFG_W-1:0] RST_ACTIVITY_GAP  = 16'd250;
    localparam logic [CFG_W-1:0] RST_PULSE_LENGTH  = 16'd90;
    localparam logic [CFG_W-1:0] RST_LOST_HALF     = 16'd500;
    localparam logic [CFG_W-1:0] RST_BROWNOUT_HALF = 16'd800;

    localparam rgb_t COLOR_BOOT      = '{red: 8'd80,  green: 8'd0,   blue: 8'd0};
    localparam rgb_t COLOR_READY     = '{red: 8'd0,   green: 8'd60,  blue: 8'd0};
    localparam rgb_t COLOR_LOST_ON   = '{red: 8'd200, green: 8'd0,   blue: 8'd0};
    localparam rgb_t COLOR_LOST_OFF  = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam rgb_t COLOR_BROWN_ON  = '{red: 8'd120, green: 8'd0,   blue: 8'd120};
    localparam rgb_t COLOR_BROWN_OFF = '{red: 8'd20,  green: 8'd0,   blue: 8'd20};
    localparam rgb_t COLOR_OFF       = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam rgb_t COLOR_PULSE     = '{red: 8'd0,   green: 8'd180, blue: 8'd0};

    function automatic rgb_t base_color(mode_t m);
        rgb_t c;
        unique case (m)
            MODE_BOOT:     c = COLOR_BOOT;
            MODE_READY:    c = COLOR_READY;
            MODE_LOST:     c = COLOR_LOST_ON;
            MODE_BROWNOUT: c = COLOR_BROWN_ON;
            default:       c = COLOR_OFF;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/slb_ifs.sv =====
// ----------------------------------------------------------------------------
// slb channel interfaces
// Valid/ready channels for beacon input items and colour results.
// ----------------------------------------------------------------------------
interface slb_item_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       action;
    logic [2:0]                       new_mode;
    logic [slb_pkg::NOW_W-1:0]        now_ms;

    modport source (output valid, action, new_mode, now_ms, input ready);
    modport sink   (input valid, action, new_mode, now_ms, output ready);
endinterface

interface slb_color_if;
    logic                             valid;
    logic                             ready;
    logic [slb_pkg::LEVEL_W-1:0]      red;
    logic [slb_pkg::LEVEL_W-1:0]      green;
    logic [slb_pkg::LEVEL_W-1:0]      blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== hw/rtl/slb_cfg.sv =====
// ----------------------------------------------------------------------------
// slb_cfg
// Configuration register file: four 16-bit timing registers, write only.
// ----------------------------------------------------------------------------
module slb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [slb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [slb_pkg::CFG_W-1:0]      wr_data,
    output slb_pkg::cfg_t                  cfg
);

    slb_pkg::cfg_t cfg_reg;
    slb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (slb_pkg::cfg_index_t'(wr_index))
                slb_pkg::CFG_ACTIVITY_GAP:  cfg_next.activity_gap_ms         = wr_data;
                slb_pkg::CFG_PULSE_LENGTH:  cfg_next.pulse_length_ms         = wr_data;
                slb_pkg::CFG_LOST_HALF:     cfg_next.lost_half_period_ms     = wr_data;
                slb_pkg::CFG_BROWNOUT_HALF: cfg_next.brownout_half_period_ms = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.activity_gap_ms         <= slb_pkg::RST_ACTIVITY_GAP;
            cfg_reg.pulse_length_ms         <= slb_pkg::RST_PULSE_LENGTH;
            cfg_reg.lost_half_period_ms     <= slb_pkg::RST_LOST_HALF;
            cfg_reg.brownout_half_period_ms <= slb_pkg::RST_BROWNOUT_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/slb_engine.sv =====
// ----------------------------------------------------------------------------
// slb_engine
// Input register, mode and timer state, colour decision and result register.
// ----------------------------------------------------------------------------
module slb_engine #(
    parameter int TIME_BITS = slb_pkg::SLB_TIME_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  slb_pkg::cfg_t cfg,
    slb_item_if.sink      item,
    slb_color_if.source   color
);

    // input register
    logic                         in_valid_reg;
    logic [1:0]                   in_action_reg;
    logic [2:0]                   in_mode_reg;
    logic [slb_pkg::NOW_W-1:0]    in_now_reg;

    // beacon state
    slb_pkg::mode_t               mode_reg, mode_next;
    logic [TIME_BITS-1:0]         toggle_reg, toggle_next;
    logic [TIME_BITS-1:0]         last_pulse_reg, last_pulse_next;
    logic [TIME_BITS-1:0]         pulse_end_reg, pulse_end_next;
    logic                         phase_reg, phase_next;

    // result register
    logic                         out_valid_reg;
    slb_pkg::rgb_t                out_color_reg;

    logic                         proc_fire;
    logic                         has_result;
    slb_pkg::rgb_t                result_color;
    logic [TIME_BITS-1:0]         now_t;
    logic [TIME_BITS-1:0]         since_pulse;
    logic [TIME_BITS-1:0]         since_toggle;
    logic [TIME_BITS-1:0]         gap_t;
    logic [TIME_BITS-1:0]         half_t;
    logic                         pulse_running;
    logic                         gap_short;

    // process the held item when the result slot is free or drains this cycle
    assign proc_fire  = in_valid_reg && (!out_valid_reg || color.ready);
    assign item.ready = !in_valid_reg || proc_fire;

    assign now_t        = TIME_BITS'(in_now_reg);
    assign since_pulse  = now_t - last_pulse_reg;
    assign since_toggle = now_t - toggle_reg;
    assign gap_t        = TIME_BITS'(cfg.activity_gap_ms);
    assign half_t       = (mode_reg == slb_pkg::MODE_LOST)
                          ? TIME_BITS'(cfg.lost_half_period_ms)
                          : TIME_BITS'(cfg.brownout_half_period_ms);
    assign pulse_running = pulse_end_reg > now_t;
    assign gap_short     = (last_pulse_reg != '0) && (since_pulse < gap_t);

    always_comb
    begin
        mode_next       = mode_reg;
        toggle_next     = toggle_reg;
        last_pulse_next = last_pulse_reg;
        pulse_end_next  = pulse_end_reg;
        phase_next      = phase_reg;
        has_result      = 1'b0;
        result_color    = slb_pkg::COLOR_OFF;

        unique case (slb_pkg::action_t'(in_action_reg))
            slb_pkg::ACT_SET:
            begin
                if (in_mode_reg <= slb_pkg::MODE_OFF)
                begin
                    mode_next       = slb_pkg::mode_t'(in_mode_reg);
                    toggle_next     = now_t;
                    last_pulse_next = '0;
                    pulse_end_next  = '0;
                    phase_next      = 1'b1;
                    has_result      = 1'b1;
                    result_color    = slb_pkg::base_color(slb_pkg::mode_t'(in_mode_reg));
                end
            end
            slb_pkg::ACT_ACTIVITY:
            begin
                if (mode_reg == slb_pkg::MODE_READY && !pulse_running && !gap_short)
                begin
                    last_pulse_next = now_t;
                    pulse_end_next  = now_t + TIME_BITS'(cfg.pulse_length_ms);
                    has_result      = 1'b1;
                    result_color    = slb_pkg::COLOR_PULSE;
                end
            end
            slb_pkg::ACT_TICK:
            begin
                unique case (mode_reg)
                    slb_pkg::MODE_READY:
                    begin
                        // end a running pulse once its end time is reached
                        if (pulse_end_reg != '0 && !pulse_running)
                        begin
                            pulse_end_next = '0;
                            has_result     = 1'b1;
                            result_color   = slb_pkg::COLOR_READY;
                        end
                    end
                    slb_pkg::MODE_LOST, slb_pkg::MODE_BROWNOUT:
                    begin
                        if (since_toggle >= half_t)
                        begin
                            phase_next  = !phase_reg;
                            toggle_next = now_t;
                            has_result  = 1'b1;
                            if (mode_reg == slb_pkg::MODE_LOST)
                                result_color = phase_reg ? slb_pkg::COLOR_LOST_OFF
                                                         : slb_pkg::COLOR_LOST_ON;
                            else
                                result_color = phase_reg ? slb_pkg::COLOR_BROWN_OFF
                                                         : slb_pkg::COLOR_BROWN_ON;
                        end
                    end
                    default:
                    begin
                        has_result = 1'b0;
                    end
                endcase
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= slb_pkg::MODE_BOOT;
            toggle_reg     <= '0;
            last_pulse_reg <= '0;
            pulse_end_reg  <= '0;
            phase_reg      <= 1'b1;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;

            if (proc_fire)
            begin
                out_valid_reg  <= has_result;
                mode_reg       <= mode_next;
                toggle_reg     <= toggle_next;
                last_pulse_reg <= last_pulse_next;
                pulse_end_reg  <= pulse_end_next;
                phase_reg      <= phase_next;
            end
            else if (color.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_action_reg <= item.action;
            in_mode_reg   <= item.new_mode;
            in_now_reg    <= item.now_ms;
        end
        if (proc_fire && has_result)
            out_color_reg <= result_color;
    end

    assign color.valid = out_valid_reg;
    assign color.red   = out_color_reg.red;
    assign color.green = out_color_reg.green;
    assign color.blue  = out_color_reg.blue;

    // a pulse can only be pending in ready mode
    a_pulse_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_end_reg != '0) |-> (mode_reg == slb_pkg::MODE_READY))
        else $error("pulse end time set outside ready mode");

    // a valid mode set always leaves a valid result on the next cycle
    a_set_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_action_reg == slb_pkg::ACT_SET
         && in_mode_reg <= slb_pkg::MODE_OFF) |=> out_valid_reg)
        else $error("mode set did not produce a colour");

    // state moves only when an item is processed
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !proc_fire |=> ($stable(mode_reg) && $stable(pulse_end_reg)
                        && $stable(phase_reg)))
        else $error("beacon state changed without an item");

    // a held result is never overwritten while stalled
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !color.ready) |-> !proc_fire)
        else $error("item processed while result stalled");

endmodule

// ===== hw/rtl/status_led_beacon_top.sv =====
// ----------------------------------------------------------------------------
// status_led_beacon_top
// Status LED colour sequencer: five modes, activity pulse and blink timers.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+---------------------------------
//   item     | in  | valid/ready  | action[1:0] new_mode[2:0] now_ms[31:0]
//   color    | out | valid/ready  | red[7:0] green[7:0] blue[7:0]
//   wr_*     | in  | wr_en only   | wr_index[1:0] wr_data[15:0]
//
// One item per cycle while the color channel is not stalled; an item passes
// the input register, then the state/result register, before its result is
// valid on the color channel.
// Latency is set by the input register and the state/result register stage.
// Items that produce no colour still pass through the stage and update state.
// A stalled color channel holds the result and backs up into item.ready.
// Reset loads the default timings, boot mode and blink phase on.
// ----------------------------------------------------------------------------
module status_led_beacon_top #(
    parameter int TIME_BITS = slb_pkg::SLB_TIME_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    slb_item_if.sink                       item,
    slb_color_if.source                    color,
    input  logic                           wr_en,
    input  logic [slb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [slb_pkg::CFG_W-1:0]      wr_data
);

    slb_pkg::cfg_t cfg;

    slb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    slb_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item),
        .color (color)
    );

endmodule

// ===== tb/sv/status_led_beacon_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// status_led_beacon_top_tb
// Drives mode, activity and tick items into the beacon with random sender idle and
// colour back-pressure. A scoreboard class predicts every colour
// write from its own copy of the timers and registers and checks each
// colour transfer in order. Runs several register settings between phases.
// ----------------------------------------------------------------------------
module status_led_beacon_top_tb;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam int         DRAIN_CYCLES  = 6;
    localparam int         HOLD_CYCLES   = 300;

    class led_color_checker;
        logic [slb_pkg::CFG_W-1:0] gap_ms;
        logic [slb_pkg::CFG_W-1:0] pulse_len_ms;
        logic [slb_pkg::CFG_W-1:0] lost_half_ms;
        logic [slb_pkg::CFG_W-1:0] brown_half_ms;
        slb_pkg::mode_t            cur_mode;
        logic [31:0]               toggle_at;
        logic [31:0]               pulse_at;
        logic [31:0]               pulse_end;
        logic                      phase_on;
        slb_pkg::rgb_t             colors_due[$];
        int                        mismatches;

        function new();
            gap_ms        = slb_pkg::RST_ACTIVITY_GAP;
            pulse_len_ms  = slb_pkg::RST_PULSE_LENGTH;
            lost_half_ms  = slb_pkg::RST_LOST_HALF;
            brown_half_ms = slb_pkg::RST_BROWNOUT_HALF;
            cur_mode      = slb_pkg::MODE_BOOT;
            toggle_at     = '0;
            pulse_at      = '0;
            pulse_end     = '0;
            phase_on      = 1'b1;
            mismatches    = 0;
        endfunction

        function void set_register(slb_pkg::cfg_index_t idx,
                                   logic [slb_pkg::CFG_W-1:0] data);
            case (idx)
                slb_pkg::CFG_ACTIVITY_GAP:  gap_ms        = data;
                slb_pkg::CFG_PULSE_LENGTH:  pulse_len_ms  = data;
                slb_pkg::CFG_LOST_HALF:     lost_half_ms  = data;
                slb_pkg::CFG_BROWNOUT_HALF: brown_half_ms = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return colors_due.size();
        endfunction

        // Advance the predicted state by one accepted item.
        function void note_item(logic [1:0] act, logic [2:0] nm, logic [31:0] now);
            logic [31:0]   elapsed;
            logic [15:0]   half;
            slb_pkg::rgb_t c;
            if (act == slb_pkg::ACT_SET) begin
                if (nm > slb_pkg::MODE_OFF)
                    return;
                cur_mode  = slb_pkg::mode_t'(nm);
                toggle_at = now;
                pulse_at  = '0;
                pulse_end = '0;
                phase_on  = 1'b1;
                case (cur_mode)
                    slb_pkg::MODE_BOOT:     c = slb_pkg::COLOR_BOOT;
                    slb_pkg::MODE_READY:    c = slb_pkg::COLOR_READY;
                    slb_pkg::MODE_LOST:     c = slb_pkg::COLOR_LOST_ON;
                    slb_pkg::MODE_BROWNOUT: c = slb_pkg::COLOR_BROWN_ON;
                    default:                c = slb_pkg::COLOR_OFF;
                endcase
                colors_due.push_back(c);
            end
            else if (act == slb_pkg::ACT_ACTIVITY) begin
                if (cur_mode != slb_pkg::MODE_READY || pulse_end > now)
                    return;
                elapsed = now - pulse_at;
                // a pulse time of zero means no pulse yet: skip the gap check
                if (pulse_at != 0 && elapsed < {16'd0, gap_ms})
                    return;
                pulse_at  = now;
                pulse_end = now + {16'd0, pulse_len_ms};
                colors_due.push_back(slb_pkg::COLOR_PULSE);
            end
            else if (act == slb_pkg::ACT_TICK) begin
                if (cur_mode == slb_pkg::MODE_READY) begin
                    if (pulse_end != 0 && now >= pulse_end) begin
                        pulse_end = '0;
                        colors_due.push_back(slb_pkg::COLOR_READY);
                    end
                end
                else if (cur_mode == slb_pkg::MODE_LOST
                         || cur_mode == slb_pkg::MODE_BROWNOUT) begin
                    half    = (cur_mode == slb_pkg::MODE_LOST) ? lost_half_ms
                                                               : brown_half_ms;
                    elapsed = now - toggle_at;
                    if (elapsed < {16'd0, half})
                        return;
                    phase_on  = !phase_on;
                    toggle_at = now;
                    if (cur_mode == slb_pkg::MODE_LOST)
                        c = phase_on ? slb_pkg::COLOR_LOST_ON : slb_pkg::COLOR_LOST_OFF;
                    else
                        c = phase_on ? slb_pkg::COLOR_BROWN_ON : slb_pkg::COLOR_BROWN_OFF;
                    colors_due.push_back(c);
                end
            end
        endfunction

        function void check_color(slb_pkg::rgb_t got);
            slb_pkg::rgb_t want;
            if (colors_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected colour transfer %0d/%0d/%0d at %0t",
                             got.red, got.green, got.blue, $time);
                return;
            end
            want = colors_due.pop_front();
            if (got.red !== want.red || got.green !== want.green
                    || got.blue !== want.blue) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("colour mismatch at %0t: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             $time, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [slb_pkg::CFG_IDX_W-1:0] wr_index;
    logic [slb_pkg::CFG_W-1:0]     wr_data;

    slb_item_if  item_ch();
    slb_color_if color_ch();

    status_led_beacon_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .color    (color_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    led_color_checker sb;
    logic [31:0]      clock_ms;
    int               sent_count;
    bit               offering;
    bit               calm;
    bit               hold_color;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic idle_sender(input int n);
        item_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(input logic [1:0] act, input logic [2:0] nm,
                             input logic [31:0] now);
        item_ch.valid    <= 1'b1;
        item_ch.action   <= act;
        item_ch.new_mode <= nm;
        item_ch.now_ms   <= now;
        offering = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        sb.note_item(act, nm, now);
        sent_count++;
        if (!calm && !hold_color && $urandom_range(0, 7) == 0)
            idle_sender(int'($urandom_range(1, 18)));
    endtask

    // Drop valid, drain every expected colour, then let silent items leave the pipe.
    task automatic settle();
        if (offering)
            idle_sender(1);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_config(input logic [slb_pkg::CFG_W-1:0] gap,
                                  input logic [slb_pkg::CFG_W-1:0] len,
                                  input logic [slb_pkg::CFG_W-1:0] lost,
                                  input logic [slb_pkg::CFG_W-1:0] brown);
        logic [slb_pkg::CFG_W-1:0] vals[4];
        slb_pkg::cfg_index_t       idx;
        vals = '{gap, len, lost, brown};
        for (int i = 0; i < 4; i++) begin
            idx = slb_pkg::cfg_index_t'(i);
            wr_en    <= 1'b1;
            wr_index <= idx;
            wr_data  <= vals[i];
            @(posedge clk);
            sb.set_register(idx, vals[i]);
        end
        wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] advance_time();
        int unsigned scale;
        scale = sb.gap_ms;
        if (sb.pulse_len_ms > scale) scale = sb.pulse_len_ms;
        if (sb.lost_half_ms > scale) scale = sb.lost_half_ms;
        if (sb.brown_half_ms > scale) scale = sb.brown_half_ms;
        scale = 2 * scale + 2;
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;
            1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
            2:       clock_ms = $urandom_range(0, 3);
            3, 4, 5, 6, 7, 8, 9, 10:
                     clock_ms = clock_ms + $urandom_range(0, 40);
            default: clock_ms = clock_ms + $urandom_range(0, scale);
        endcase
        return clock_ms;
    endfunction

    task automatic run_random(input int n);
        int          done;
        int          k;
        logic [2:0]  nm;
        logic [1:0]  act;
        logic [31:0] now;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 9) < 7) begin
                // well-formed session: enter a mode, then drive its timers
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: nm = slb_pkg::MODE_READY;
                    5, 6:          nm = slb_pkg::MODE_LOST;
                    7, 8:          nm = slb_pkg::MODE_BROWNOUT;
                    default:       nm = 3'($urandom_range(slb_pkg::MODE_BOOT,
                                                          slb_pkg::MODE_OFF));
                endcase
                send_item(slb_pkg::ACT_SET, nm, advance_time());
                done++;
                k = $urandom_range(3, 14);
                repeat (k) begin
                    if (nm == slb_pkg::MODE_READY)
                        act = $urandom_range(0, 1) ? slb_pkg::ACT_ACTIVITY
                                                   : slb_pkg::ACT_TICK;
                    else
                        act = ($urandom_range(0, 7) == 0) ? slb_pkg::ACT_ACTIVITY
                                                          : slb_pkg::ACT_TICK;
                    send_item(act, 3'($urandom_range(0, 7)), advance_time());
                    done++;
                end
            end
            else begin
                act = 2'($urandom_range(0, 3));
                nm  = 3'($urandom_range(0, 7));
                now = $urandom_range(0, 1) ? $urandom : advance_time();
                send_item(act, nm, now);
                if (act != ACT_UNUSED && !(act == slb_pkg::ACT_SET && nm > slb_pkg::MODE_OFF))
                    done++;
            end
        end
    endtask

    // Receiver: check colour transfers, stall in random bursts or on hold-off.
    initial
    begin
        int            stall_left;
        slb_pkg::rgb_t got;
        stall_left = 0;
        color_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (color_ch.valid === 1'b1 && color_ch.ready === 1'b1) begin
                got.red   = color_ch.red;
                got.green = color_ch.green;
                got.blue  = color_ch.blue;
                sb.check_color(got);
            end
            if (hold_color) begin
                color_ch.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                color_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = int'($urandom_range(1, 18)) - 1;
                color_ch.ready <= 1'b0;
            end
            else begin
                color_ch.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering: fill the pipe.
    initial
    begin
        hold_color = 1'b0;
        wait (sent_count >= 400);
        @(posedge clk);
        hold_color = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_color = 1'b0;
    end

    initial
    begin
        sb         = new();
        clock_ms   = '0;
        sent_count = 0;
        offering   = 1'b0;
        calm       = 1'b0;
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= slb_pkg::CFG_ACTIVITY_GAP;
        wr_data          <= '0;
        item_ch.valid    <= 1'b0;
        item_ch.action   <= slb_pkg::ACT_SET;
        item_ch.new_mode <= slb_pkg::MODE_BOOT;
        item_ch.now_ms   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored items in boot mode and unknown codes, then off mode and a tick in it
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_BOOT, 32'd0);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_BOOT, 32'd5);
        send_item(ACT_UNUSED, slb_pkg::MODE_READY, 32'd7);
        send_item(slb_pkg::ACT_SET, MODE_UNDEF_LO, 32'd8);
        send_item(slb_pkg::ACT_SET, MODE_UNDEF_HI, 32'd9);
        send_item(slb_pkg::ACT_SET, slb_pkg::MODE_OFF, 32'hFFFF_FFFF);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_OFF, 32'hFFFF_FFFF);
        // ready: pulse, pulse still running, tick end, pulse at time zero, gap
        send_item(slb_pkg::ACT_SET, slb_pkg::MODE_READY, 32'd0);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'd0);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'd50);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_READY, 32'd89);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_READY, 32'd90);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'd100);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_READY, 32'd190);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'd300);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'd350);
        // pulse end wraps to zero
        send_item(slb_pkg::ACT_SET, slb_pkg::MODE_READY, 32'hFFFF_FFF0);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'hFFFF_FFA6);
        send_item(slb_pkg::ACT_ACTIVITY, slb_pkg::MODE_READY, 32'hFFFF_FFB0);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_READY, 32'hFFFF_FFFF);
        // blink toggles, brownout across the time wrap
        send_item(slb_pkg::ACT_SET, slb_pkg::MODE_LOST, 32'd1000);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_LOST, 32'd1499);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_LOST, 32'd1500);
        send_item(slb_pkg::ACT_SET, slb_pkg::MODE_BROWNOUT, 32'hFFFF_FF00);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_BROWNOUT, 32'h0000_021F);
        send_item(slb_pkg::ACT_TICK, slb_pkg::MODE_BROWNOUT, 32'h0000_0220);

        run_random(250);
        for (int phase = 1; phase <= 5; phase++) begin
            settle();
            case (phase)
                1: program_config(16'd0, 16'd0, 16'd0, 16'd0);
                2: program_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: program_config(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
                                  16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
                4: program_config(16'd1, 16'hFFFF, 16'd0, 16'd1);
                default:
                begin
                    calm = 1'b1;
                    program_config(slb_pkg::RST_ACTIVITY_GAP, slb_pkg::RST_PULSE_LENGTH,
                                   slb_pkg::RST_LOST_HALF, slb_pkg::RST_BROWNOUT_HALF);
                end
            endcase
            run_random((phase == 3 || phase == 5) ? 300 : 200);
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
